/* rtl/sidl_pkg.sv */
// ----------------------------------------------------------------------------
// sidl_pkg: shared types and constants of the shift insert/delete list
// Request and status codes, cell operation codes and the control word
// broadcast to every cell of the list.
// ----------------------------------------------------------------------------
package sidl_pkg;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    // wide enough for any index and for a count up to the largest capacity
    localparam int BCAST_W  = 9;
    // words OR-ed per group in the first read reduction stage
    localparam int RED_GROUP = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [BCAST_W-1:0]    lo;
        logic [BCAST_W-1:0]    hi;
        logic                  rd_en;
        logic [BCAST_W-1:0]    rd_idx;
        logic [VALUE_W-1:0]    value;
    } cell_ctrl_t;

endpackage

/* rtl/sidl_cell.sv */
// ----------------------------------------------------------------------------
// sidl_cell: one slot of the list
// Holds one word; loads the new word, takes the left or right neighbor's
// word, or holds, and captures its word for the read path when selected.
// ----------------------------------------------------------------------------
module sidl_cell #(
    parameter int IDX = 0
) (
    input  logic                       aclk,
    input  logic                       en,
    input  sidl_pkg::cell_ctrl_t       ctrl,
    input  logic [sidl_pkg::VALUE_W-1:0] left_word,
    input  logic [sidl_pkg::VALUE_W-1:0] right_word,
    output logic [sidl_pkg::VALUE_W-1:0] word,
    output logic [sidl_pkg::VALUE_W-1:0] rd_word
);
    import sidl_pkg::*;

    localparam logic [BCAST_W-1:0] MY_IDX = BCAST_W'(IDX);

    logic [VALUE_W-1:0] word_reg, word_next;
    logic [VALUE_W-1:0] rd_reg, rd_next;

    always_comb begin
        word_next = word_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (MY_IDX == ctrl.lo) begin
                    word_next = ctrl.value;
                end else if (MY_IDX > ctrl.lo && MY_IDX <= ctrl.hi) begin
                    word_next = left_word;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= ctrl.lo && MY_IDX < ctrl.hi) begin
                    word_next = right_word;
                end
            end
            default: word_next = word_reg;
        endcase
        rd_next = (ctrl.rd_en && MY_IDX == ctrl.rd_idx) ? word_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
            rd_reg   <= rd_next;
        end
    end

    assign word    = word_reg;
    assign rd_word = rd_reg;

endmodule

/* rtl/sidl_reduce.sv */
// ----------------------------------------------------------------------------
// sidl_reduce: read path reduction
// ORs the masked cell words in registered groups, then ORs the groups.
// ----------------------------------------------------------------------------
module sidl_reduce #(
    parameter int N = 16
) (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [sidl_pkg::VALUE_W-1:0] words [N],
    output logic [sidl_pkg::VALUE_W-1:0] result
);
    import sidl_pkg::*;

    localparam int GROUPS = (N + RED_GROUP - 1) / RED_GROUP;

    logic [VALUE_W-1:0] grp_reg  [GROUPS];
    logic [VALUE_W-1:0] grp_next [GROUPS];

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < RED_GROUP; k++) begin
                if (g * RED_GROUP + k < N) begin
                    grp_next[g] = grp_next[g] | words[g * RED_GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int g = 0; g < GROUPS; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb begin
        result = '0;
        for (int g = 0; g < GROUPS; g++) begin
            result = result | grp_reg[g];
        end
    end

endmodule

/* rtl/shift_insert_delete_list.sv */
// ----------------------------------------------------------------------------
// shift_insert_delete_list: ordered list of signed words with fixed capacity
// A row of cells holds the list; insert and delete shift the cells from the
// position to the count one slot over, at once, when a request is accepted.
//
// Channels: s_ carries requests (mode, position, value), m_ carries one
// result beat per request (read value, status, count after the request).
// Each request passes cell capture, the grouped OR stage and the output
// register; a new request waits until the previous one has passed cell
// capture and the grouped OR stage and has reached the output register.
// Insert and delete are as fast as other requests: cells shift in parallel.
// Reset clears the count and the pipeline; slot contents are not cleared
// and are only read below the count.
// When the receiver stalls, the result holds on m_ and the block takes at
// most one further request, whose result waits in the reduction stage.
// ----------------------------------------------------------------------------
module shift_insert_delete_list #(
    parameter int CAPACITY = 16,
    localparam int CW    = $clog2(CAPACITY + 1),
    localparam int OUT_W = ((sidl_pkg::VALUE_W + sidl_pkg::STATUS_W + CW + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,   // mode[2:0], position[10:3], value[42:11]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // read_value[31:0], status[33:32], count
);
    import sidl_pkg::*;

    localparam logic [BCAST_W-1:0] CAP_B = BCAST_W'(CAPACITY);

    logic [MODE_W-1:0]  req_mode;
    logic [POS_W-1:0]   req_pos;
    logic [VALUE_W-1:0] req_value;

    assign req_mode  = s_tdata[MODE_W-1:0];
    assign req_pos   = s_tdata[MODE_W +: POS_W];
    assign req_value = s_tdata[MODE_W + POS_W +: VALUE_W];

    logic [CW-1:0]      count_reg, count_next;
    logic               p0_reg, p1_reg, ov_reg;
    status_t            st0_reg, st1_reg, st_out_reg, st_next;
    logic [CW-1:0]      cnt0_reg, cnt1_reg, cnt_out_reg;
    logic [VALUE_W-1:0] rd_out_reg;
    cell_ctrl_t         ctrl;
    logic               accept, out_load, adv01;
    logic [BCAST_W-1:0] cnt_b, pos_b, cnt_b_next;
    logic               full;

    logic [VALUE_W-1:0] words    [CAPACITY];
    logic [VALUE_W-1:0] rd_words [CAPACITY];
    logic [VALUE_W-1:0] rd_sum;

    assign s_tready = !p0_reg && !p1_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_load = p1_reg && (!ov_reg || m_tready);
    assign adv01    = p0_reg && (!p1_reg || out_load);

    assign cnt_b = BCAST_W'(count_reg);
    assign pos_b = BCAST_W'(req_pos);
    assign full  = cnt_b >= CAP_B;

    always_comb begin
        ctrl.op     = CELL_HOLD;
        ctrl.lo     = pos_b;
        ctrl.hi     = cnt_b;
        ctrl.rd_en  = 1'b0;
        ctrl.rd_idx = pos_b;
        ctrl.value  = req_value;
        st_next     = ST_OK;
        cnt_b_next  = cnt_b;
        case (req_mode)
            MODE_PUSH: begin
                if (full) begin
                    st_next = ST_FULL;
                end else begin
                    ctrl.op    = CELL_INSERT;
                    ctrl.lo    = cnt_b;
                    cnt_b_next = cnt_b + 1'b1;
                end
            end
            MODE_POP: begin
                if (cnt_b == '0) begin
                    st_next = ST_EMPTY;
                end else begin
                    ctrl.rd_en  = 1'b1;
                    ctrl.rd_idx = cnt_b - 1'b1;
                    cnt_b_next  = cnt_b - 1'b1;
                end
            end
            MODE_INSERT: begin
                if (pos_b > cnt_b) begin
                    st_next = ST_RANGE;
                end else if (full) begin
                    st_next = ST_FULL;
                end else begin
                    ctrl.op    = CELL_INSERT;
                    cnt_b_next = cnt_b + 1'b1;
                end
            end
            MODE_DELETE: begin
                if (pos_b >= cnt_b) begin
                    st_next = ST_RANGE;
                end else begin
                    ctrl.op    = CELL_DELETE;
                    ctrl.hi    = cnt_b - 1'b1;
                    cnt_b_next = cnt_b - 1'b1;
                end
            end
            MODE_READ: begin
                if (pos_b >= cnt_b) begin
                    st_next = ST_RANGE;
                end else begin
                    ctrl.rd_en = 1'b1;
                end
            end
            default: st_next = ST_OK;
        endcase
        count_next = accept ? cnt_b_next[CW-1:0] : count_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = words[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = words[i+1];
        end
        sidl_cell #(.IDX(i)) u_cell (
            .aclk       (aclk),
            .en         (accept),
            .ctrl       (ctrl),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i]),
            .rd_word    (rd_words[i])
        );
    end

    sidl_reduce #(.N(CAPACITY)) u_reduce (
        .aclk   (aclk),
        .load   (adv01),
        .words  (rd_words),
        .result (rd_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            p0_reg    <= 1'b0;
            p1_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            p0_reg    <= accept || (p0_reg && !adv01);
            p1_reg    <= adv01 || (p1_reg && !out_load);
            ov_reg    <= out_load || (ov_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st0_reg  <= st_next;
            cnt0_reg <= cnt_b_next[CW-1:0];
        end
        if (adv01) begin
            st1_reg  <= st0_reg;
            cnt1_reg <= cnt0_reg;
        end
        if (out_load) begin
            rd_out_reg  <= rd_sum;
            st_out_reg  <= st1_reg;
            cnt_out_reg <= cnt1_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = OUT_W'({cnt_out_reg, st_out_reg, rd_out_reg});

endmodule

/* rtl/sidl_checker.sv */
// ----------------------------------------------------------------------------
// sidl_checker: port-level checks of the shift insert/delete list
// Watches the request and result channels and flags results that
// contradict the list's own rules.
// ----------------------------------------------------------------------------
module sidl_checker #(
    parameter int CAPACITY = 16,
    localparam int CW    = $clog2(CAPACITY + 1),
    localparam int OUT_W = ((sidl_pkg::VALUE_W + sidl_pkg::STATUS_W + CW + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    import sidl_pkg::*;

    logic [VALUE_W-1:0]  rd_val;
    logic [STATUS_W-1:0] st;
    logic [CW-1:0]       cnt;

    assign rd_val = m_tdata[VALUE_W-1:0];
    assign st     = m_tdata[VALUE_W +: STATUS_W];
    assign cnt    = m_tdata[VALUE_W + STATUS_W +: CW];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request beat taken while one is in flight");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_EMPTY |-> cnt == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_FULL |-> cnt == CW'(CAPACITY))
        else $error("full status with count below capacity");

    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rd_val != '0 |-> st == ST_OK)
        else $error("nonzero read value on failed request");

endmodule

bind shift_insert_delete_list sidl_checker #(.CAPACITY(CAPACITY)) u_sidl_checker (.*);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the shift insert/delete list
// Sends request beats (push, pop, insert, delete, read and the unused modes)
// through a short table of hand-picked cases, then about 1750 random
// requests. The random requests drift between filling and draining the list
// so that the full and empty edges are hit often. A shadow list in the bench
// predicts each result beat, and the beats are checked in order.
// ----------------------------------------------------------------------------
module tb_top;

    import sidl_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1750;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [31:0] read_value;
        status_t     status;
        logic [4:0]  count;
    } list_result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  pos;
        logic [31:0] val;
        int          reps;
        bit          typed;
        logic [31:0] exp_rd;
        status_t     exp_st;
        logic [4:0]  exp_cnt;
    } req_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int src_idle_pct = 37;
    int dst_idle_pct = 80;

    logic [31:0]  list_words [DEPTH];
    int           list_len = 0;
    list_result_t pending_results [$];

    int mismatches = 0;
    int results_seen = 0;
    int mode_tally [8];
    int status_tally [4];

    req_row_t directed_rows [0:18];

    shift_insert_delete_list #(
        .CAPACITY(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAILURE");
        $finish;
    end

    task automatic predict_list_result(input logic [2:0] mode, input logic [7:0] pos,
                                       input logic [31:0] val, output list_result_t res);
        res.read_value = '0;
        res.status     = ST_OK;
        case (mode)
            MODE_PUSH: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            MODE_POP: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_len--;
                    res.read_value = list_words[list_len];
                end
            end
            MODE_INSERT: begin
                if (pos > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            MODE_DELETE: begin
                if (pos >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            MODE_READ: begin
                if (pos >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = list_words[pos];
                end
            end
            default: ;
        endcase
        res.count = list_len[4:0];
        mode_tally[mode]++;
        status_tally[res.status]++;
    endtask

    // call at or after an acceptance edge; returns at the edge this beat is taken
    task automatic send_req(input logic [2:0] mode, input logic [7:0] pos,
                            input logic [31:0] val, input bit typed,
                            input list_result_t typed_res);
        list_result_t res;
        @(negedge aclk);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, pos, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_list_result(mode, pos, val, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        list_result_t want;
        logic [31:0]  got_rd;
        logic [1:0]   got_st;
        logic [4:0]   got_cnt;
        if (aresetn && m_tvalid && m_tready) begin
            got_rd  = m_tdata[31:0];
            got_st  = m_tdata[33:32];
            got_cnt = m_tdata[38:34];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: rd=%h st=%0d cnt=%0d",
                             got_rd, got_st, got_cnt);
            end else begin
                want = pending_results.pop_front();
                if (got_rd !== want.read_value || got_st !== want.status ||
                    got_cnt !== want.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch beat %0d: exp %h/%0d/%0d, got %h/%0d/%0d",
                                 results_seen, want.read_value, want.status, want.count,
                                 got_rd, got_st, got_cnt);
                end
            end
        end
    end

    initial begin
        list_result_t typed_res;
        logic [2:0]   req_mode;
        logic [7:0]   req_pos;
        int           pick;
        int           top;
        int           bias_left;
        bit           growing;

        foreach (list_words[i]) list_words[i] = '0;
        foreach (mode_tally[i]) mode_tally[i] = 0;
        foreach (status_tally[i]) status_tally[i] = 0;

        directed_rows = '{
            '{MODE_POP,        8'd0,   32'h0000_0000, 1,  1'b1, 32'h0, ST_EMPTY, 5'd0},
            '{MODE_DELETE,     8'd255, 32'h0000_0000, 1,  1'b1, 32'h0, ST_RANGE, 5'd0},
            '{MODE_READ,       8'd0,   32'h0000_0000, 1,  1'b1, 32'h0, ST_RANGE, 5'd0},
            '{MODE_INSERT,     8'd1,   32'h1234_5678, 1,  1'b1, 32'h0, ST_RANGE, 5'd0},
            '{MODE_INSERT,     8'd0,   32'h8000_0000, 1,  1'b1, 32'h0, ST_OK,    5'd1},
            '{MODE_PUSH,       8'd0,   32'h7FFF_FFFF, 1,  1'b1, 32'h0, ST_OK,    5'd2},
            '{MODE_READ,       8'd1,   32'h0000_0000, 1,  1'b1, 32'h7FFF_FFFF, ST_OK, 5'd2},
            '{MODE_SPARE_LAST, 8'd255, 32'hFFFF_FFFF, 1,  1'b1, 32'h0, ST_OK,    5'd2},
            '{MODE_INSERT,     8'd1,   32'h55AA_AA55, 1,  1'b0, 32'h0, ST_OK,    5'd0},
            '{MODE_PUSH,       8'd0,   32'h0F0F_3C3C, 13, 1'b0, 32'h0, ST_OK,    5'd0},
            '{MODE_PUSH,       8'd0,   32'hDEAD_BEEF, 1,  1'b1, 32'h0, ST_FULL,  5'd16},
            '{MODE_INSERT,     8'd16,  32'hDEAD_BEEF, 1,  1'b1, 32'h0, ST_FULL,  5'd16},
            '{MODE_INSERT,     8'd17,  32'hDEAD_BEEF, 1,  1'b1, 32'h0, ST_RANGE, 5'd16},
            '{MODE_READ,       8'd15,  32'h0000_0000, 1,  1'b0, 32'h0, ST_OK,    5'd0},
            '{MODE_DELETE,     8'd0,   32'h0000_0000, 1,  1'b0, 32'h0, ST_OK,    5'd0},
            '{MODE_DELETE,     8'd14,  32'h0000_0000, 1,  1'b0, 32'h0, ST_OK,    5'd0},
            '{MODE_READ,       8'd14,  32'h0000_0000, 1,  1'b1, 32'h0, ST_RANGE, 5'd14},
            '{MODE_POP,        8'd0,   32'h0000_0000, 1,  1'b0, 32'h0, ST_OK,    5'd0},
            '{MODE_INSERT,     8'd13,  32'hA5A5_5A5A, 1,  1'b0, 32'h0, ST_OK,    5'd0}
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                typed_res.read_value = directed_rows[r].exp_rd;
                typed_res.status     = directed_rows[r].exp_st;
                typed_res.count      = directed_rows[r].exp_cnt;
                send_req(directed_rows[r].mode, directed_rows[r].pos,
                         directed_rows[r].val + k * 32'h1111_1111,
                         directed_rows[r].typed, typed_res);
            end
        end

        growing   = 1'b1;
        bias_left = $urandom_range(80, 20);
        typed_res = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                src_idle_pct = 80;
                dst_idle_pct = 37;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            if (bias_left == 0) begin
                growing   = ~growing;
                bias_left = $urandom_range(80, 20);
            end
            bias_left--;

            pick = $urandom_range(99, 0);
            if (pick < 4) begin
                req_mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
            end else if (growing) begin
                req_mode = (pick < 34) ? MODE_PUSH : (pick < 58) ? MODE_INSERT :
                           (pick < 68) ? MODE_POP  : (pick < 78) ? MODE_DELETE : MODE_READ;
            end else begin
                req_mode = (pick < 14) ? MODE_PUSH : (pick < 24) ? MODE_INSERT :
                           (pick < 49) ? MODE_POP  : (pick < 74) ? MODE_DELETE : MODE_READ;
            end

            top = (req_mode == MODE_INSERT) ? list_len : list_len - 1;
            if (top >= 0 && $urandom_range(99, 0) < 85)
                req_pos = 8'($urandom_range(top, 0));
            else
                req_pos = 8'($urandom_range(255, 0));

            send_req(req_mode, req_pos, $urandom, 1'b0, typed_res);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("requests: push %0d, pop %0d, insert %0d, delete %0d, read %0d, unused %0d",
                 mode_tally[MODE_PUSH], mode_tally[MODE_POP], mode_tally[MODE_INSERT],
                 mode_tally[MODE_DELETE], mode_tally[MODE_READ],
                 mode_tally[5] + mode_tally[6] + mode_tally[7]);
        $display("outcomes: ok %0d, out of range %0d, full %0d, empty %0d; %0d beats checked",
                 status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_FULL],
                 status_tally[ST_EMPTY], results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/sidl_pkg.sv
rtl/sidl_cell.sv
rtl/sidl_reduce.sv
rtl/shift_insert_delete_list.sv
rtl/sidl_checker.sv
bench/tb_top.sv
